// ----- hdl/conv3x3_spatial_filter_top_macros.svh -----
// ----------------------------------------------------------------------------
// conv3x3 spatial filter assertion macros
// Shared concurrent assertion forms for the filter's modules
// ----------------------------------------------------------------------------
`ifndef CONV3X3_SPATIAL_FILTER_TOP_MACROS_SVH
`define CONV3X3_SPATIAL_FILTER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CONV3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv3 filter check failed");

// next-cycle implication, disabled while in reset
`define CONV3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv3 filter check failed");

`endif

// ----- hdl/conv3_pkg.sv -----
// ----------------------------------------------------------------------------
// conv3 package
// Types, widths and register codes shared by the 3x3 filter modules
// ----------------------------------------------------------------------------
package conv3_pkg;

    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 8;
    localparam int PROD_W         = PIX_W + 1 + COEF_W;
    localparam int CSUM_W         = PROD_W + 2;
    localparam int SUM_W          = CSUM_W + 2;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int DIM_W          = 12;
    localparam int ROW_W          = DIM_W + 1;
    localparam int PIX_MAX        = 255;

    // highest row count a frame can reach, tallest frame plus one
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(1 << DIM_W);

    // register reset values
    localparam logic [CFG_DATA_W-1:0] COEF_ROW0_RST = '0;
    localparam logic [CFG_DATA_W-1:0] COEF_ROW1_RST = CFG_DATA_W'(256);
    localparam logic [CFG_DATA_W-1:0] COEF_ROW2_RST = '0;
    localparam logic [DIM_W-1:0]      WIDTH_RST     = DIM_W'(640);
    localparam logic [DIM_W-1:0]      HEIGHT_RST    = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_ROW0    = 3'd0,
        REG_COEF_ROW1    = 3'd1,
        REG_COEF_ROW2    = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } t_cfg_reg;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef t_pix [2:0]               t_col;   // [0] top, [1] middle, [2] bottom
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [2:0]              t_kcol;  // kernel column, top to bottom

    typedef struct packed {
        logic step;       // a column enters the chain
        logic clr;        // row start: the cell empties instead of taking its input
        logic snap_zero;  // row start: the cell offers a zero column to the kernel
        logic mac_en;     // the column sum register may load
    } t_cell_ctrl;

endpackage

// ----- hdl/conv3_line_buf.sv -----
// ----------------------------------------------------------------------------
// conv3 line buffer
// Two row memories with a clearing sweep after reset and write forwarding
// ----------------------------------------------------------------------------
`include "conv3x3_spatial_filter_top_macros.svh"

module conv3_line_buf #(
    parameter int MAX_WIDTH = 2048,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic                i_wr_en,
    input  conv3_pkg::t_pix     i_wr_bot,
    output conv3_pkg::t_pix     o_top_raw,
    output conv3_pkg::t_pix     o_mid_raw,
    output logic                o_busy
);
    import conv3_pkg::*;

    t_pix mem_a [MAX_WIDTH];
    t_pix mem_b [MAX_WIDTH];

    t_pix              r_rd_a;
    t_pix              r_rd_b;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_fwd_vld;
    logic [ADDR_W-1:0] r_fwd_addr;
    t_pix              r_fwd_a;
    t_pix              r_fwd_b;

    logic              w_hit;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_addr;
    t_pix              w_mem_a;
    t_pix              w_mem_b;

    // the latest write wins over a read issued in the same cycle
    always_comb begin
        w_hit     = r_fwd_vld && (r_fwd_addr == i_addr);
        o_top_raw = w_hit ? r_fwd_a : r_rd_a;
        o_mid_raw = w_hit ? r_fwd_b : r_rd_b;
    end

    // write port shared by the clearing sweep and the pixel path
    always_comb begin
        w_mem_we   = r_clearing || i_wr_en;
        w_mem_addr = r_clearing ? r_clr_addr : i_addr;
        w_mem_a    = r_clearing ? '0 : o_mid_raw;
        w_mem_b    = r_clearing ? '0 : i_wr_bot;
    end

    // row memories
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_a[w_mem_addr] <= w_mem_a;
            mem_b[w_mem_addr] <= w_mem_b;
        end
        if (i_rd_en) begin
            r_rd_a <= mem_a[i_rd_addr];
            r_rd_b <= mem_b[i_rd_addr];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // last pixel-path write, kept for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (r_clearing) begin
            r_fwd_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_addr <= i_addr;
            r_fwd_a    <= o_mid_raw;
            r_fwd_b    <= i_wr_bot;
        end
    end

    assign o_busy = r_clearing;

    // checks
    `CONV3_ASSERT_IMPL(a_no_write_in_sweep, i_clk, i_rst_n, r_clearing, !i_wr_en)
    `CONV3_ASSERT_IMPL(a_no_read_in_sweep, i_clk, i_rst_n, r_clearing, !i_rd_en)
    `CONV3_ASSERT_IMPL(a_fwd_empty_after_sweep, i_clk, i_rst_n, $fell(r_clearing), !r_fwd_vld)

endmodule

// ----- hdl/conv3_cell.sv -----
// ----------------------------------------------------------------------------
// conv3 window cell
// One column of the 3x3 window with its three kernel taps and column sum
// ----------------------------------------------------------------------------
module conv3_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  conv3_pkg::t_cell_ctrl              i_ctrl,
    input  conv3_pkg::t_col                    i_shift_in,
    input  conv3_pkg::t_kcol                   i_coef,
    output conv3_pkg::t_col                    o_col,
    output logic signed [conv3_pkg::CSUM_W-1:0] o_colsum
);
    import conv3_pkg::*;

    t_col                     r_col;
    t_col                     r_snap;
    logic signed [CSUM_W-1:0] r_colsum;
    logic signed [PROD_W-1:0] w_prod [3];
    logic signed [CSUM_W-1:0] n_colsum;

    // window column, handed on to the left neighbour on every step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctrl.step) begin
            r_col <= i_ctrl.clr ? '0 : i_shift_in;
        end
    end

    // column as the kernel sees it for this output
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_snap <= i_ctrl.snap_zero ? '0 : i_shift_in;
        end
    end

    // three taps and their sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_prod[r] = PROD_W'($signed({1'b0, r_snap[r]})) * PROD_W'(i_coef[r]);
        end
        n_colsum = CSUM_W'(w_prod[0]) + CSUM_W'(w_prod[1]) + CSUM_W'(w_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac_en) begin
            r_colsum <= n_colsum;
        end
    end

    assign o_col    = r_col;
    assign o_colsum = r_colsum;

endmodule

// ----- hdl/conv3x3_spatial_filter_top.sv -----
// ----------------------------------------------------------------------------
// conv3x3 spatial filter top level
// Takes one grey pixel per clock in raster order and returns one filtered pixel
// per clock, sustained while the output stream is not stalled, whatever the frame
// size. A pixel passes the line buffer read, the window cells, the column sums
// and the output register, in that order; in stream terms the output lags the
// input by frame_width+1 items, and the items of the top row and the first item
// of the second row give no result. After reset the two row memories are swept
// to zero, one address per clock; no pixel is taken during the sweep,
// configuration writes are. After the last row send frame_width+1 flush items
// (tuser high); the final result carries tlast.
// ----------------------------------------------------------------------------
`include "conv3x3_spatial_filter_top_macros.svh"

module conv3x3_spatial_filter_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // [7:0] pixel_in
    input  logic                              i_s_axis_tuser,   // [0] kind, 1 for flush
    // filtered output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // [7:0] pixel_out
    output logic                              o_m_axis_tlast    // frame_last
);
    import conv3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = COL_W + 1;
    localparam int CMP_W = ROW_W + 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_coef [3];
    logic [DIM_W-1:0]      r_frame_width;
    logic [DIM_W-1:0]      r_frame_height;

    // raster position
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // pipeline stage registers
    logic             r_v1;
    logic [COL_W-1:0] r_addr1;
    logic             r_x0_1;
    logic             r_top_gate1;
    logic             r_mid_gate1;
    t_pix             r_bot1;
    logic             r_emit1;
    logic             r_last1;
    logic             r_v2;
    logic             r_last2;
    logic             r_v3;
    logic             r_last3;
    logic             r_ov;
    t_pix             r_out_pix;
    logic             r_out_last;

    // control
    logic en_o, en3, en2, en1, w_move12, w_accept, w_busy;
    logic [DIM_W-1:0] w_fw_nz, w_h_eff;
    logic [WID_W-1:0] w_w_eff, w_col_inc;
    logic [CMP_W-1:0] w_y, w_h;
    logic w_x0, w_last, w_bot_gate, w_emit, w_wrap;
    t_pix w_bot;

    // datapath
    t_pix                     w_top_raw, w_mid_raw;
    t_col                     w_new_col;
    t_col                     w_cell_col [3];
    t_col                     w_cell_in  [3];
    t_kcol                    w_kcol     [3];
    t_cell_ctrl               w_ctrl     [3];
    logic signed [CSUM_W-1:0] w_colsum   [3];
    logic signed [SUM_W-1:0]  n_sum, w_shift;
    t_pix                     n_out_pix;

    // configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]      <= COEF_ROW0_RST;
            r_coef[1]      <= COEF_ROW1_RST;
            r_coef[2]      <= COEF_ROW2_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_COEF_ROW0:    r_coef[0] <= i_cfg_data;
                REG_COEF_ROW1:    r_coef[1] <= i_cfg_data;
                REG_COEF_ROW2:    r_coef[2] <= i_cfg_data;
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow, each stage moves when the one after it has room
    always_comb begin
        en_o     = !r_ov || i_m_axis_tready;
        en3      = !r_v3 || en_o;
        en2      = !r_v2 || en3;
        en1      = !r_v1 || en2;
        w_move12 = r_v1 && en2;
    end

    assign o_s_axis_tready = en1 && !w_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // effective frame size and position decode
    always_comb begin
        w_fw_nz   = (r_frame_width == '0) ? DIM_W'(1) : r_frame_width;
        w_w_eff   = ({20'd0, w_fw_nz} > 32'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
                                                        : WID_W'(w_fw_nz);
        w_h_eff   = (r_frame_height == '0) ? DIM_W'(1) : r_frame_height;
        w_y       = {1'b0, r_row};
        w_h       = {2'b00, w_h_eff};
        w_x0      = (r_col == '0);
        w_last    = (w_y > w_h);
        w_bot_gate = (w_y < w_h);
        w_emit    = w_x0 ? ((r_row >= ROW_W'(2)) && (w_y < w_h + CMP_W'(2)))
                         : ((r_row != '0) && (w_y <= w_h));
        w_col_inc = {1'b0, r_col} + WID_W'(1);
        w_wrap    = (w_col_inc >= w_w_eff);
        w_bot     = (!i_s_axis_tuser && w_bot_gate) ? i_s_axis_tdata : '0;
    end

    // next raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_last) begin
            n_col = '0;
            n_row = '0;
        end else if (w_wrap) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = w_col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage one: item waits for its line buffer read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr1     <= r_col;
            r_x0_1      <= w_x0;
            r_top_gate1 <= (r_row >= ROW_W'(2));
            r_mid_gate1 <= (r_row != '0);
            r_bot1      <= w_bot;
            r_emit1     <= w_emit;
            r_last1     <= w_last;
        end
    end

    conv3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .i_addr    (r_addr1),
        .i_wr_en   (w_move12),
        .i_wr_bot  (r_bot1),
        .o_top_raw (w_top_raw),
        .o_mid_raw (w_mid_raw),
        .o_busy    (w_busy)
    );

    // new column entering the window, rows above the frame read as zero
    always_comb begin
        w_new_col[0] = r_top_gate1 ? w_top_raw : '0;
        w_new_col[1] = r_mid_gate1 ? w_mid_raw : '0;
        w_new_col[2] = r_bot1;
    end

    // chain of window cells, right-hand cell takes the new column
    assign w_cell_in[0] = w_cell_col[1];
    assign w_cell_in[1] = w_cell_col[2];
    assign w_cell_in[2] = w_new_col;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        for (genvar r = 0; r < 3; r++) begin : g_tap
            assign w_kcol[k][r] = r_coef[r][COEF_W*k +: COEF_W];
        end

        always_comb begin
            w_ctrl[k].step      = w_move12;
            w_ctrl[k].clr       = (k != 2) && r_x0_1;
            w_ctrl[k].snap_zero = (k == 2) && r_x0_1;
            w_ctrl[k].mac_en    = en3;
        end

        conv3_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[k]),
            .i_shift_in (w_cell_in[k]),
            .i_coef     (w_kcol[k]),
            .o_col      (w_cell_col[k]),
            .o_colsum   (w_colsum[k])
        );
    end

    // stage two and three valids, items without a result drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= r_v1 && r_emit1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move12) begin
            r_last2 <= r_last1;
        end
        if (en3) begin
            r_last3 <= r_last2;
        end
    end

    // final sum, floor and clamp
    always_comb begin
        n_sum   = SUM_W'(w_colsum[0]) + SUM_W'(w_colsum[1]) + SUM_W'(w_colsum[2]);
        w_shift = n_sum >>> COEF_FRAC_BITS;
        if (n_sum <= 0) begin
            n_out_pix = '0;
        end else if (w_shift > SUM_W'(PIX_MAX)) begin
            n_out_pix = PIX_W'(PIX_MAX);
        end else begin
            n_out_pix = w_shift[PIX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_v3) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_last3;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tlast  = r_out_last;

    // checks
    `CONV3_ASSERT_NEXT(a_frame_end_rewinds, i_clk, i_rst_n, w_accept && w_last, (r_row == '0) && (r_col == '0))
    `CONV3_ASSERT_IMPL(a_out_from_stage3, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(r_v3))
    `CONV3_ASSERT_IMPL(a_row_bounded, i_clk, i_rst_n, 1'b1, r_row <= ROW_LIMIT)

endmodule
